// ===== hdl/mls_pkg.sv =====
// ============================================================================
// mls_pkg
// Shared types, constants and lookup functions for the Morse lamp signaller.
// ============================================================================
package mls_pkg;

    localparam int TICK_COUNT_WIDTH = 20;
    localparam int PERIOD_WIDTH     = 20;

    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << TICK_COUNT_WIDTH) - 64'd1);

    localparam logic [PERIOD_WIDTH-1:0] SYMBOL_TICKS_RST = PERIOD_WIDTH'(500);
    localparam logic [PERIOD_WIDTH-1:0] GAP_TICKS_RST    = PERIOD_WIDTH'(1000);
    localparam logic [PERIOD_WIDTH-1:0] END_TICKS_RST    = PERIOD_WIDTH'(1000);

    localparam logic [1:0] REG_SYMBOL_TICKS = 2'd0;
    localparam logic [1:0] REG_GAP_TICKS    = 2'd1;
    localparam logic [1:0] REG_END_TICKS    = 2'd2;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_LETTER = 2'd1;
    localparam logic [1:0] FUNC_END    = 2'd2;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SYMBOL = 2'd1;
    localparam logic [1:0] PH_GAP    = 2'd2;
    localparam logic [1:0] PH_END    = 2'd3;

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_Z = 8'h7A;

    typedef logic [TICK_COUNT_WIDTH-1:0] tick_count_t;

    typedef struct packed {
        logic red_lamp;
        logic yellow_lamp;
        logic green_lamp;
        logic busy_res;
        logic accepted;
    } res_t;

    // zero counts as one tick; saturate to the counter range
    function automatic tick_count_t load_period(input logic [PERIOD_WIDTH-1:0] period);
        logic [31:0] p;
        p = 32'(period);
        if (p == 32'd0)
        begin
            p = 32'd1;
        end
        if (p > COUNT_MAX)
        begin
            p = COUNT_MAX;
        end
        return TICK_COUNT_WIDTH'(p);
    endfunction

    // high nibble: length, low nibble: pattern (bit set = dash)
    function automatic logic [7:0] morse_entry(input logic [4:0] idx);
        logic [7:0] e;
        case (idx)
            5'd0:    e = 8'h22;
            5'd1:    e = 8'h41;
            5'd2:    e = 8'h45;
            5'd3:    e = 8'h31;
            5'd4:    e = 8'h10;
            5'd5:    e = 8'h44;
            5'd6:    e = 8'h33;
            5'd7:    e = 8'h40;
            5'd8:    e = 8'h20;
            5'd9:    e = 8'h4E;
            5'd10:   e = 8'h35;
            5'd11:   e = 8'h42;
            5'd12:   e = 8'h23;
            5'd13:   e = 8'h21;
            5'd14:   e = 8'h37;
            5'd15:   e = 8'h46;
            5'd16:   e = 8'h4B;
            5'd17:   e = 8'h32;
            5'd18:   e = 8'h30;
            5'd19:   e = 8'h11;
            5'd20:   e = 8'h34;
            5'd21:   e = 8'h48;
            5'd22:   e = 8'h36;
            5'd23:   e = 8'h49;
            5'd24:   e = 8'h4D;
            5'd25:   e = 8'h43;
            default: e = 8'h00;
        endcase
        return e;
    endfunction

endpackage

// ===== hdl/mls_res_fifo.sv =====
// ============================================================================
// mls_res_fifo
// Two-entry result queue; decouples the state update from the output side.
// ============================================================================
module mls_res_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mls_pkg::res_t push_data,
    output logic          full,
    output logic          out_valid,
    input  logic          out_ready,
    output mls_pkg::res_t out_data
);

    mls_pkg::res_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hdl/morse_led_signaler.sv =====
// ============================================================================
// morse_led_signaler
// Morse lamp signaller: ticks, letters and end-of-word commands drive lamps.
// ============================================================================
// Each result is registered in the result queue when its item is accepted.
// Throughput: one item per cycle while the result queue is not full; the state update is a single registered pass.
// A two-entry result queue lets items enter while a result waits to be taken.
// Reset: phase idle, counters clear, periods return to 500/1000/1000 ticks.
// Configuration writes are always accepted (cfg_ready is tied high) and update the period registers directly.
module morse_led_signaler (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       red_lamp,
    output logic       yellow_lamp,
    output logic       green_lamp,
    output logic       busy_res,
    output logic       accepted,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [19:0] cfg_data
);

    logic [mls_pkg::PERIOD_WIDTH-1:0] symbol_ticks_reg;
    logic [mls_pkg::PERIOD_WIDTH-1:0] gap_ticks_reg;
    logic [mls_pkg::PERIOD_WIDTH-1:0] end_ticks_reg;

    logic [1:0]           phase_reg;
    logic [1:0]           phase_next;
    logic [3:0]           pattern_reg;
    logic [3:0]           pattern_next;
    logic [2:0]           length_reg;
    logic [2:0]           length_next;
    logic [2:0]           pos_reg;
    logic [2:0]           pos_next;
    mls_pkg::tick_count_t count_reg;
    mls_pkg::tick_count_t count_next;
    mls_pkg::tick_count_t count_dec;
    logic                 acc_next;
    logic [7:0]           entry;
    logic [7:0]           letter_off;
    logic                 is_letter;
    logic                 dash;
    logic                 in_fire;
    logic                 fifo_full;
    mls_pkg::res_t        res;
    mls_pkg::res_t        out_res;

    assign in_ready  = !fifo_full;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign letter_off = char_code - mls_pkg::CHAR_A;
    assign is_letter  = (char_code >= mls_pkg::CHAR_A) && (char_code <= mls_pkg::CHAR_Z);
    assign entry      = mls_pkg::morse_entry(letter_off[4:0]);
    assign count_dec  = (count_reg != '0) ? count_reg - mls_pkg::tick_count_t'(1) : count_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        pattern_next = pattern_reg;
        length_next  = length_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        acc_next     = 1'b0;
        case (func)
            mls_pkg::FUNC_TICK:
            begin
                if (phase_reg != mls_pkg::PH_IDLE)
                begin
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        if (phase_reg == mls_pkg::PH_SYMBOL)
                        begin
                            pos_next = pos_reg + 3'd1;
                            if (pos_next < length_reg)
                            begin
                                count_next = mls_pkg::load_period(symbol_ticks_reg);
                            end
                            else
                            begin
                                phase_next = mls_pkg::PH_GAP;
                                count_next = mls_pkg::load_period(gap_ticks_reg);
                            end
                        end
                        else
                        begin
                            phase_next = mls_pkg::PH_IDLE;
                        end
                    end
                end
            end
            mls_pkg::FUNC_LETTER:
            begin
                if (phase_reg == mls_pkg::PH_IDLE)
                begin
                    acc_next = 1'b1;
                    pos_next = 3'd0;
                    if (is_letter)
                    begin
                        pattern_next = entry[3:0];
                        length_next  = entry[6:4];
                        phase_next   = mls_pkg::PH_SYMBOL;
                        count_next   = mls_pkg::load_period(symbol_ticks_reg);
                    end
                    else
                    begin
                        pattern_next = 4'd0;
                        length_next  = 3'd0;
                        phase_next   = mls_pkg::PH_GAP;
                        count_next   = mls_pkg::load_period(gap_ticks_reg);
                    end
                end
            end
            mls_pkg::FUNC_END:
            begin
                if (phase_reg == mls_pkg::PH_IDLE)
                begin
                    acc_next   = 1'b1;
                    phase_next = mls_pkg::PH_END;
                    count_next = mls_pkg::load_period(end_ticks_reg);
                end
            end
            default:
            begin
                acc_next = 1'b0;
            end
        endcase
    end

    assign dash = pattern_next[pos_next[1:0]];

    always_comb
    begin
        res.red_lamp    = (phase_next == mls_pkg::PH_SYMBOL) && !dash;
        res.yellow_lamp = (phase_next == mls_pkg::PH_SYMBOL) && dash;
        res.green_lamp  = (phase_next == mls_pkg::PH_END);
        res.busy_res    = (phase_next != mls_pkg::PH_IDLE);
        res.accepted    = acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= mls_pkg::PH_IDLE;
            pattern_reg <= 4'd0;
            length_reg  <= 3'd0;
            pos_reg     <= 3'd0;
            count_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            pattern_reg <= pattern_next;
            length_reg  <= length_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_ticks_reg <= mls_pkg::SYMBOL_TICKS_RST;
            gap_ticks_reg    <= mls_pkg::GAP_TICKS_RST;
            end_ticks_reg    <= mls_pkg::END_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mls_pkg::REG_SYMBOL_TICKS: symbol_ticks_reg <= cfg_data;
                mls_pkg::REG_GAP_TICKS:    gap_ticks_reg    <= cfg_data;
                mls_pkg::REG_END_TICKS:    end_ticks_reg    <= cfg_data;
                default:                   symbol_ticks_reg <= symbol_ticks_reg;
            endcase
        end
    end

    mls_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (res),
        .full      (fifo_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res)
    );

    assign red_lamp    = out_res.red_lamp;
    assign yellow_lamp = out_res.yellow_lamp;
    assign green_lamp  = out_res.green_lamp;
    assign busy_res    = out_res.busy_res;
    assign accepted    = out_res.accepted;

`ifndef SYNTHESIS
    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mls_pkg::PH_IDLE) |-> (count_reg == '0))
        else $error("idle with ticks outstanding");

    a_busy_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != mls_pkg::PH_IDLE) |-> (count_reg != '0))
        else $error("busy with empty tick counter");

    a_symbol_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mls_pkg::PH_SYMBOL) |-> (pos_reg < length_reg))
        else $error("symbol position past pattern length");

    a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (phase_reg != mls_pkg::PH_IDLE) && (func != mls_pkg::FUNC_TICK))
        |=> $stable(phase_reg) && $stable(count_reg))
        else $error("refused command altered state");

    a_lamps_imply_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (red_lamp || yellow_lamp || green_lamp))
        |-> (busy_res && $onehot({red_lamp, yellow_lamp, green_lamp})))
        else $error("lamp lit while idle or several lamps lit");
`endif

endmodule
